// ===== hdl/srms_pkg.sv =====
// Shared types, codes and tables of the ramped stepper move sequencer.
`default_nettype none

package srms_pkg;

    // Field widths
    localparam int MODE_W  = 3;
    localparam int CNT_W   = 16;
    localparam int PHASE_W = 2;
    localparam int DLY_W   = 8;
    localparam int RAMP_W  = 15;
    localparam int MAP_W   = 8;
    localparam int COIL_W  = 4;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 15;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    // Divider: 24-bit dividend, one quotient bit per cycle
    localparam int DIV_W    = 24;
    localparam int DIV_CW   = 5;
    localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_W - 1);

    // Input item kinds
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MOVE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SWING   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SETPH   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd4;

    // Register indexes
    localparam logic [CFG_AW-1:0] CFG_START_DELAY = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MIN_DELAY   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_RAMP_LENGTH = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_LINE_ROUTE  = 2'd3;

    // Register reset values
    localparam logic [DLY_W-1:0]  START_DELAY_RST = 8'd14;
    localparam logic [DLY_W-1:0]  MIN_DELAY_RST   = 8'd2;
    localparam logic [RAMP_W-1:0] RAMP_LENGTH_RST = 15'd600;
    localparam logic [MAP_W-1:0]  LINE_ROUTE_RST  = 8'd228;

    // Motion stage
    typedef enum logic [2:0] {
        STG_IDLE = 3'd0,
        STG_MOVE = 3'd1,
        STG_OUT  = 3'd2,
        STG_HOLD = 3'd3,
        STG_BACK = 3'd4
    } stage_t;

    // Controller states
    typedef enum logic [2:0] {
        C_IDLE,
        C_EVAL,
        C_WSEL,
        C_MUL,
        C_DIV,
        C_FIN,
        C_EMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic wsel;
        logic mul;
        logic div_step;
        logic fin;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic step_taken;
        logic use_div;
        logic slot_free;
    } dp_status_t;

    // Full-step two-coil pattern; bit k is pattern bit k
    function automatic logic [COIL_W-1:0] full_step_pattern(input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] p;
        unique case (ph)
            2'd0: p = 4'h3;
            2'd1: p = 4'h6;
            2'd2: p = 4'hC;
            2'd3: p = 4'h9;
            default: p = 4'h3;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/stepper_ramped_move_sequencer.sv =====
// Top level of the ramped full-step stepper move sequencer.
//
// Input channel s_*: one transaction per 1 ms tick or command, kind in s_tuser.
// Result channel m_*: exactly one result transaction per input transaction.
// User must write settings (cfg_we/cfg_addr/cfg_wdata) only while idle; unenforced.
//
// Each input transaction is taken in one cycle and evaluated in the next. The
// result is loaded into the output register in state EMIT. EMIT follows EVAL
// for an item that takes no step, EVAL and WSEL for a step at cruise speed, and
// EVAL, WSEL, MUL, DIV and FIN for a step on a ramp, where the restoring divider
// works out the ramp wait one quotient bit a cycle. The next transaction can be
// accepted in the cycle after the load. One item is in work at a time; the next
// is accepted once the previous result sits in the output register, even while
// that result is not taken.
//
// Reset (aresetn low, synchronous) stops any move, turns the coils off, sets
// the phase to zero and loads the default settings. When the receiver stalls
// the result is held in the output register and at most one further input
// transaction is accepted and evaluated before the input side stalls too.
`default_nettype none

module stepper_ramped_move_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input transactions
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] step_count, [16] reverse, [18:17] phase_value, [34:19] hold_time
    input  wire logic [39:0] s_tdata,
    // [2:0] mode
    input  wire logic [2:0]  s_tuser,
    // Result transactions
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] coil_levels, [5:4] current_phase, [6] busy_res, [7] done_res, [8] ignored
    output logic [15:0]      m_tdata,
    // Settings write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [14:0] cfg_wdata
);

    srms_pkg::dp_cmd_t    cmd;
    srms_pkg::dp_status_t status;

    srms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srms_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== hdl/srms_ctrl.sv =====
// Sequencing state machine of the ramped stepper move sequencer.
`default_nettype none

module srms_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire srms_pkg::dp_status_t status,
    output srms_pkg::dp_cmd_t       cmd
);

    srms_pkg::ctrl_state_t state_reg, state_next;
    logic [srms_pkg::DIV_CW-1:0] cnt_reg, cnt_next;

    // State and divider step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srms_pkg::C_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            srms_pkg::C_IDLE: begin
                if (s_tvalid) state_next = srms_pkg::C_EVAL;
            end
            srms_pkg::C_EVAL: begin
                state_next = status.step_taken ? srms_pkg::C_WSEL : srms_pkg::C_EMIT;
            end
            srms_pkg::C_WSEL: begin
                state_next = status.use_div ? srms_pkg::C_MUL : srms_pkg::C_EMIT;
            end
            srms_pkg::C_MUL: begin
                cnt_next   = '0;
                state_next = srms_pkg::C_DIV;
            end
            srms_pkg::C_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == srms_pkg::DIV_LAST) state_next = srms_pkg::C_FIN;
            end
            srms_pkg::C_FIN: begin
                state_next = srms_pkg::C_EMIT;
            end
            srms_pkg::C_EMIT: begin
                if (status.slot_free) state_next = srms_pkg::C_IDLE;
            end
            default: state_next = srms_pkg::C_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            srms_pkg::C_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            srms_pkg::C_EVAL: cmd.eval     = 1'b1;
            srms_pkg::C_WSEL: cmd.wsel     = 1'b1;
            srms_pkg::C_MUL:  cmd.mul      = 1'b1;
            srms_pkg::C_DIV:  cmd.div_step = 1'b1;
            srms_pkg::C_FIN:  cmd.fin      = 1'b1;
            srms_pkg::C_EMIT: cmd.load_out = status.slot_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/srms_dp.sv =====
// Datapath: motion state, step wait arithmetic, settings and output register.
`default_nettype none

module srms_dp (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [srms_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire logic [srms_pkg::MODE_W-1:0]        s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [srms_pkg::OUT_TDATA_W-1:0]        m_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [srms_pkg::CFG_AW-1:0]        cfg_addr,
    input  wire logic [srms_pkg::CFG_DW-1:0]        cfg_wdata,
    input  wire srms_pkg::dp_cmd_t                  cmd,
    output srms_pkg::dp_status_t                    status
);

    // Settings
    logic [srms_pkg::DLY_W-1:0]  start_delay_reg, min_delay_reg;
    logic [srms_pkg::RAMP_W-1:0] ramp_length_reg;
    logic [srms_pkg::MAP_W-1:0]  line_route_reg;

    // Captured transaction
    logic [srms_pkg::MODE_W-1:0]  mode_reg;
    logic [srms_pkg::CNT_W-1:0]   cnt_in_reg, hold_in_reg;
    logic                         rev_in_reg;
    logic [srms_pkg::PHASE_W-1:0] ph_in_reg;

    // Motion state
    logic [srms_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                         coils_reg, coils_next;
    srms_pkg::stage_t             stage_reg, stage_next;
    logic [srms_pkg::CNT_W-1:0]   step_index_reg, step_index_next;
    logic [srms_pkg::CNT_W-1:0]   total_reg, total_next;
    logic [srms_pkg::RAMP_W-1:0]  ramp_reg, ramp_next;
    logic                         mrev_reg, mrev_next;
    logic [srms_pkg::DLY_W-1:0]   delay_reg, delay_next;
    logic [srms_pkg::CNT_W-1:0]   hold_reg, hold_next;
    logic                         done_reg, done_next;
    logic                         ign_reg, ign_next;
    logic                         step_go;

    // Divider
    logic [srms_pkg::DIV_W-1:0]  quo_reg;
    logic [srms_pkg::CNT_W-1:0]  rem_reg;

    // Output register
    logic                                m_tvalid_reg;
    logic [srms_pkg::OUT_TDATA_W-1:0]    m_tdata_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_delay_reg <= srms_pkg::START_DELAY_RST;
            min_delay_reg   <= srms_pkg::MIN_DELAY_RST;
            ramp_length_reg <= srms_pkg::RAMP_LENGTH_RST;
            line_route_reg  <= srms_pkg::LINE_ROUTE_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                srms_pkg::CFG_START_DELAY: start_delay_reg <= cfg_wdata[srms_pkg::DLY_W-1:0];
                srms_pkg::CFG_MIN_DELAY:   min_delay_reg   <= cfg_wdata[srms_pkg::DLY_W-1:0];
                srms_pkg::CFG_RAMP_LENGTH: ramp_length_reg <= cfg_wdata;
                srms_pkg::CFG_LINE_ROUTE:  line_route_reg  <= cfg_wdata[srms_pkg::MAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture of the input transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg    <= s_tuser;
            cnt_in_reg  <= s_tdata[15:0];
            rev_in_reg  <= s_tdata[16];
            ph_in_reg   <= s_tdata[18:17];
            hold_in_reg <= s_tdata[34:19];
        end
    end

    // Item evaluation: stage transitions, leg start and phase step
    logic [srms_pkg::CNT_W-1:0]  idx_inc, leg_cnt;
    logic                        leg_go, leg_rev, step_dir;
    logic [srms_pkg::RAMP_W-1:0] r_lim;
    logic [srms_pkg::DLY_W-1:0]  dl_dec;
    logic [srms_pkg::CNT_W-1:0]  hl_dec;

    always_comb begin
        phase_next      = phase_reg;
        coils_next      = coils_reg;
        stage_next      = stage_reg;
        step_index_next = step_index_reg;
        total_next      = total_reg;
        ramp_next       = ramp_reg;
        mrev_next       = mrev_reg;
        delay_next      = delay_reg;
        hold_next       = hold_reg;
        done_next       = 1'b0;
        ign_next        = 1'b0;
        step_go         = 1'b0;
        leg_go          = 1'b0;
        leg_cnt         = total_reg;
        leg_rev         = ~mrev_reg;
        idx_inc         = step_index_reg + 16'd1;
        dl_dec          = (delay_reg != '0) ? delay_reg - 8'd1 : delay_reg;
        hl_dec          = (hold_reg != '0) ? hold_reg - 16'd1 : hold_reg;
        r_lim           = '0;

        if (stage_reg != srms_pkg::STG_IDLE) begin
            if (mode_reg == srms_pkg::MODE_MOVE || mode_reg == srms_pkg::MODE_SWING ||
                mode_reg == srms_pkg::MODE_SETPH || mode_reg == srms_pkg::MODE_RELEASE) begin
                ign_next = 1'b1;
            end else if (mode_reg == srms_pkg::MODE_TICK) begin
                if (stage_reg == srms_pkg::STG_HOLD) begin
                    hold_next = hl_dec;
                    if (hl_dec == '0) begin
                        stage_next = srms_pkg::STG_BACK;
                        leg_go     = 1'b1;
                    end
                end else begin
                    delay_next = dl_dec;
                    if (dl_dec == '0) begin
                        step_index_next = idx_inc;
                        if (idx_inc < total_reg) begin
                            step_go = 1'b1;
                        end else if (stage_reg == srms_pkg::STG_OUT) begin
                            if (hold_reg == '0) begin
                                stage_next = srms_pkg::STG_BACK;
                                leg_go     = 1'b1;
                            end else begin
                                stage_next = srms_pkg::STG_HOLD;
                            end
                        end else begin
                            if (stage_reg == srms_pkg::STG_BACK) coils_next = 1'b0;
                            stage_next = srms_pkg::STG_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                end
            end
        end else begin
            priority if (mode_reg == srms_pkg::MODE_MOVE && cnt_in_reg != '0) begin
                stage_next = srms_pkg::STG_MOVE;
                leg_go     = 1'b1;
                leg_cnt    = cnt_in_reg;
                leg_rev    = rev_in_reg;
            end else if (mode_reg == srms_pkg::MODE_SWING && cnt_in_reg != '0) begin
                stage_next = srms_pkg::STG_OUT;
                hold_next  = hold_in_reg;
                leg_go     = 1'b1;
                leg_cnt    = cnt_in_reg;
                leg_rev    = rev_in_reg;
            end else if (mode_reg == srms_pkg::MODE_SETPH) begin
                phase_next = ph_in_reg;
                coils_next = 1'b1;
            end else if (mode_reg == srms_pkg::MODE_RELEASE) begin
                coils_next = 1'b0;
            end else begin
            end
        end

        // Leg start: ramp clamped to half the step count
        if (leg_go) begin
            r_lim = (ramp_length_reg == '0) ? 15'd1 : ramp_length_reg;
            if ({r_lim, 1'b0} > leg_cnt) r_lim = leg_cnt[srms_pkg::CNT_W-1:1];
            total_next      = leg_cnt;
            ramp_next       = r_lim;
            mrev_next       = leg_rev;
            step_index_next = '0;
            step_go         = 1'b1;
        end

        // Phase advance
        step_dir = leg_go ? leg_rev : mrev_reg;
        if (step_go) begin
            phase_next = step_dir ? phase_reg - 2'd1 : phase_reg + 2'd1;
            coils_next = 1'b1;
        end
    end

    // Wait selection from the state left by the evaluation
    logic [srms_pkg::DLY_W-1:0] mn, st, diff;
    logic [srms_pkg::CNT_W-1:0] thr, mult_b;
    logic                       use_div;

    always_comb begin
        mn      = (min_delay_reg == '0) ? 8'd1 : min_delay_reg;
        st      = (start_delay_reg < mn) ? mn : start_delay_reg;
        diff    = st - mn;
        thr     = total_reg - {1'b0, ramp_reg};
        use_div = 1'b0;
        mult_b  = step_index_reg;
        if (ramp_reg != '0 && step_index_reg < {1'b0, ramp_reg}) begin
            use_div = 1'b1;
        end else if (ramp_reg != '0 && step_index_reg >= thr) begin
            use_div = 1'b1;
            mult_b  = total_reg - 16'd1 - step_index_reg;
        end
    end

    // Divider trial subtraction
    logic [srms_pkg::CNT_W-1:0] trial;
    logic                       fits;
    assign trial = {rem_reg[srms_pkg::CNT_W-2:0], quo_reg[srms_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, ramp_reg};

    // Multiply, then restoring division one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            quo_reg <= srms_pkg::DIV_W'(diff) * srms_pkg::DIV_W'(mult_b);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= fits ? trial - {1'b0, ramp_reg} : trial;
            quo_reg <= {quo_reg[srms_pkg::DIV_W-2:0], fits};
        end
    end

    // Motion state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= '0;
            coils_reg      <= 1'b0;
            stage_reg      <= srms_pkg::STG_IDLE;
            step_index_reg <= '0;
            total_reg      <= '0;
            ramp_reg       <= '0;
            mrev_reg       <= 1'b0;
            delay_reg      <= '0;
            hold_reg       <= '0;
            done_reg       <= 1'b0;
            ign_reg        <= 1'b0;
        end else if (cmd.eval) begin
            phase_reg      <= phase_next;
            coils_reg      <= coils_next;
            stage_reg      <= stage_next;
            step_index_reg <= step_index_next;
            total_reg      <= total_next;
            ramp_reg       <= ramp_next;
            mrev_reg       <= mrev_next;
            delay_reg      <= delay_next;
            hold_reg       <= hold_next;
            done_reg       <= done_next;
            ign_reg        <= ign_next;
        end else if (cmd.wsel && !use_div) begin
            delay_reg <= mn;
        end else if (cmd.fin) begin
            delay_reg <= st - quo_reg[srms_pkg::DLY_W-1:0];
        end
    end

    // Coil lines through the wire map
    logic [srms_pkg::COIL_W-1:0] pat, lines;
    always_comb begin
        pat = srms_pkg::full_step_pattern(phase_reg);
        for (int n = 0; n < srms_pkg::COIL_W; n++) begin
            lines[n] = coils_reg & pat[line_route_reg[2*n +: 2]];
        end
    end

    // Output register: held until the downstream transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {7'd0, ign_reg, done_reg,
                            (stage_reg != srms_pkg::STG_IDLE), phase_reg, lines};
        end
    end

    // A step is taken by the item under evaluation
    assign m_tvalid          = m_tvalid_reg;
    assign m_tdata           = m_tdata_reg;
    assign status.step_taken = step_go;
    assign status.use_div    = use_div;
    assign status.slot_free  = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

// ===== tb/move_sequence_checker.sv =====
// Watches both channels and the settings port, predicts each result and compares it.
module move_sequence_checker
    import srms_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // [15:0] step_count, [16] reverse, [18:17] phase_value, [34:19] hold_time
    input  wire logic [39:0] s_tdata,
    // [2:0] mode
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // [3:0] coil_levels, [5:4] current_phase, [6] busy_res, [7] done_res, [8] ignored
    input  wire logic [15:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [14:0] cfg_wdata,
    output int               fail_total,
    output int               pending,
    output logic             motor_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] coils;
        logic [1:0] phase;
        logic       busy;
        logic       done;
        logic       ignored;
    } motor_status_t;

    // Settings copy
    logic [7:0]  start_dly;
    logic [7:0]  min_dly;
    logic [14:0] ramp_len;
    logic [7:0]  line_route;

    // Motor state copy
    stage_t      stage;
    logic [1:0]  phase;
    logic        coils_on;
    logic [15:0] step_idx;
    logic [15:0] total;
    logic [14:0] ramp_used;
    logic        rev_dir;
    logic [7:0]  delay_left;
    logic [15:0] hold_left;

    motor_status_t expected_status[$];
    motor_status_t want;
    motor_status_t seen;
    int            fail_count;
    int            result_no;

    // Wait after step i: linear ramp down, cruise, linear ramp up
    function automatic logic [7:0] ramp_wait(input logic [15:0] i);
        int unsigned mn, st, r, tot;
        mn  = (min_dly < 8'd1) ? 1 : min_dly;
        st  = (start_dly < mn) ? mn : start_dly;
        r   = ramp_used;
        tot = total;
        if (r != 0 && i < r)
            return 8'(st - ((st - mn) * i) / r);
        if (r != 0 && i >= tot - r)
            return 8'(st - ((st - mn) * (tot - 1 - i)) / r);
        return 8'(mn);
    endfunction

    function automatic void take_step();
        phase      = rev_dir ? phase - 2'd1 : phase + 2'd1;
        coils_on   = 1'b1;
        delay_left = ramp_wait(step_idx);
    endfunction

    // Ramp is clamped to half the leg
    function automatic void start_leg(input logic [15:0] count, input logic rev);
        int unsigned r;
        r = (ramp_len < 15'd1) ? 1 : ramp_len;
        if (2 * r > count) r = count / 2;
        total     = count;
        ramp_used = 15'(r);
        rev_dir   = rev;
        step_idx  = '0;
        take_step();
    endfunction

    // Two-coil full-step pattern routed to the output lines
    function automatic logic [3:0] line_levels();
        logic [3:0] pat;
        logic [3:0] lv;
        if (!coils_on) return 4'h0;
        case (phase)
            2'd0:    pat = 4'h3;
            2'd1:    pat = 4'h6;
            2'd2:    pat = 4'hC;
            default: pat = 4'h9;
        endcase
        for (int n = 0; n < 4; n++)
            lv[n] = pat[line_route[2*n +: 2]];
        return lv;
    endfunction

    function automatic motor_status_t predict_status(input logic [2:0] mode,
                                                     input logic [15:0] cnt,
                                                     input logic rev,
                                                     input logic [1:0] ph,
                                                     input logic [15:0] hold);
        motor_status_t res;
        logic done_now;
        logic dropped;
        done_now = 1'b0;
        dropped  = 1'b0;
        if (stage != STG_IDLE) begin
            if (mode >= MODE_MOVE && mode <= MODE_RELEASE) begin
                dropped = 1'b1;
            end else if (mode == MODE_TICK) begin
                if (stage == STG_HOLD) begin
                    if (hold_left != 0) hold_left--;
                    if (hold_left == 0) begin
                        stage = STG_BACK;
                        start_leg(total, ~rev_dir);
                    end
                end else begin
                    if (delay_left != 0) delay_left--;
                    if (delay_left == 0) begin
                        step_idx++;
                        if (step_idx < total) begin
                            take_step();
                        end else if (stage == STG_OUT) begin
                            // zero hold turns straight round on this tick
                            if (hold_left == 0) begin
                                stage = STG_BACK;
                                start_leg(total, ~rev_dir);
                            end else begin
                                stage = STG_HOLD;
                            end
                        end else begin
                            if (stage == STG_BACK) coils_on = 1'b0;
                            stage    = STG_IDLE;
                            done_now = 1'b1;
                        end
                    end
                end
            end
        end else begin
            if (mode == MODE_MOVE && cnt != 0) begin
                stage = STG_MOVE;
                start_leg(cnt, rev);
            end else if (mode == MODE_SWING && cnt != 0) begin
                stage     = STG_OUT;
                hold_left = hold;
                start_leg(cnt, rev);
            end else if (mode == MODE_SETPH) begin
                phase    = ph;
                coils_on = 1'b1;
            end else if (mode == MODE_RELEASE) begin
                coils_on = 1'b0;
            end
        end
        res.coils   = line_levels();
        res.phase   = phase;
        res.busy    = (stage != STG_IDLE);
        res.done    = done_now;
        res.ignored = dropped;
        return res;
    endfunction

    // Results are checked before the same edge's input is predicted
    always @(posedge aclk) begin
        if (!aresetn) begin
            start_dly  = START_DELAY_RST;
            min_dly    = MIN_DELAY_RST;
            ramp_len   = RAMP_LENGTH_RST;
            line_route = LINE_ROUTE_RST;
            stage      = STG_IDLE;
            phase      = '0;
            coils_on   = 1'b0;
            step_idx   = '0;
            total      = '0;
            ramp_used  = '0;
            rev_dir    = 1'b0;
            delay_left = '0;
            hold_left  = '0;
            fail_count = 0;
            result_no  = 0;
            expected_status.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_START_DELAY: start_dly  = cfg_wdata[7:0];
                    CFG_MIN_DELAY:   min_dly    = cfg_wdata[7:0];
                    CFG_RAMP_LENGTH: ramp_len   = cfg_wdata;
                    CFG_LINE_ROUTE:  line_route = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                seen.coils   = m_tdata[3:0];
                seen.phase   = m_tdata[5:4];
                seen.busy    = m_tdata[6];
                seen.done    = m_tdata[7];
                seen.ignored = m_tdata[8];
                if (expected_status.size() == 0) begin
                    if (fail_count < 10)
                        $display("result %0d: no transaction outstanding, tdata %h",
                                 result_no, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_status.pop_front();
                    if (seen != want) begin
                        if (fail_count < 10)
                            $display({"result %0d mismatch: exp coils %h ph %0d busy %b ",
                                      "done %b ign %b, got coils %h ph %0d busy %b ",
                                      "done %b ign %b"}, result_no,
                                     want.coils, want.phase, want.busy, want.done,
                                     want.ignored, seen.coils, seen.phase, seen.busy,
                                     seen.done, seen.ignored);
                        fail_count++;
                    end
                end
                result_no++;
            end
            if (s_tvalid && s_tready)
                expected_status.push_back(predict_status(s_tuser, s_tdata[15:0],
                                                         s_tdata[16], s_tdata[18:17],
                                                         s_tdata[34:19]));
        end
        pending    <= expected_status.size();
        motor_busy <= (stage != STG_IDLE);
        fail_total <= fail_count;
    end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus and verdict for the ramped stepper move sequencer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srms_pkg::*;

    // Modes with no function
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = MODE_TICK;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = CFG_START_DELAY;
    logic [14:0] cfg_wdata = '0;

    int   fail_total;
    int   pending;
    logic motor_busy;

    int burst_left       = 0;
    int items_sent       = 0;
    int moves_issued     = 0;
    int swings_issued    = 0;
    int settings_written = 0;

    // Receiver stall pattern
    int         rx_mode    = 0;
    int         seg_left   = 0;
    int         stall_left = 0;
    logic [1:0] rx_count   = '0;

    always #6 aclk = ~aclk;

    stepper_ramped_move_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    move_sequence_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_total (fail_total),
        .pending    (pending),
        .motor_busy (motor_busy)
    );

    // Receiver: segments of always ready, coin toss, fixed 1-in-4 and long stalls
    always @(posedge aclk) begin
        if (seg_left == 0) begin
            rx_mode  <= $urandom_range(0, 3);
            seg_left <= $urandom_range(100, 500);
        end else begin
            seg_left <= seg_left - 1;
        end
        rx_count <= rx_count + 2'd1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_count == 2'd3);
            default: begin
                if (stall_left != 0) begin
                    m_tready   <= 1'b0;
                    stall_left <= stall_left - 1;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(4, 20);
                end
            end
        endcase
    end

    // One input transaction, sent in bursts with random gaps
    task automatic push_item(input logic [2:0] mode, input logic [15:0] cnt,
                             input logic rev, input logic [1:0] ph,
                             input logic [15:0] hold);
        int gap;
        if (burst_left <= 0) begin
            case ($urandom_range(0, 9))
                0, 1:       gap = 0;
                2, 3, 4, 5: gap = $urandom_range(1, 3);
                6, 7, 8:    gap = $urandom_range(4, 10);
                default:    gap = $urandom_range(11, 25);
            endcase
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'b0, hold, ph, rev, cnt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic push_tick();
        push_item(MODE_TICK, 16'($urandom), 1'($urandom), 2'($urandom), 16'($urandom));
    endtask

    // Hold the sender until every result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Tick until the motor is idle; busy lags one transaction, so one idle tick may slip in
    task automatic settle();
        wait_drained();
        while (motor_busy) begin
            while (motor_busy) push_tick();
            wait_drained();
        end
    endtask

    task automatic write_settings(input logic [7:0] st, input logic [7:0] mn,
                                  input logic [14:0] rl, input logic [7:0] wm);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_START_DELAY;
        cfg_wdata <= 15'(st);
        @(posedge aclk);
        cfg_addr  <= CFG_MIN_DELAY;
        cfg_wdata <= 15'(mn);
        @(posedge aclk);
        cfg_addr  <= CFG_RAMP_LENGTH;
        cfg_wdata <= rl;
        @(posedge aclk);
        cfg_addr  <= CFG_LINE_ROUTE;
        cfg_wdata <= 15'(wm);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings_written++;
    endtask

    // Random traffic: ticks while moving, commands while idle, some noise
    task automatic run_phase(input int budget, input int max_cnt, input int max_hold);
        int          pick;
        logic [2:0]  mode;
        logic [15:0] cnt;
        logic [15:0] hold;
        logic        rev;
        logic [1:0]  ph;
        for (int n = 0; n < budget; n++) begin
            cnt  = 16'($urandom);
            hold = 16'($urandom);
            rev  = 1'($urandom);
            ph   = 2'($urandom);
            pick = $urandom_range(0, 99);
            if (motor_busy) begin
                if (pick < 88)
                    mode = MODE_TICK;
                else if (pick < 96)
                    mode = 3'($urandom_range(MODE_MOVE, MODE_RELEASE));
                else
                    mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            end else if (pick < 34) begin
                mode = MODE_MOVE;
                cnt  = 16'($urandom_range(1, max_cnt));
                moves_issued++;
            end else if (pick < 56) begin
                mode = MODE_SWING;
                cnt  = 16'($urandom_range(1, max_cnt));
                hold = ($urandom_range(0, 3) == 0) ? 16'd0
                                                   : 16'($urandom_range(1, max_hold));
                swings_issued++;
            end else if (pick < 66) begin
                mode = MODE_SETPH;
            end else if (pick < 74) begin
                mode = MODE_RELEASE;
            end else if (pick < 84) begin
                mode = MODE_TICK;
            end else if (pick < 90) begin
                mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            end else begin
                mode = pick[0] ? MODE_MOVE : MODE_SWING;
                cnt  = '0;
            end
            push_item(mode, cnt, rev, ph, hold);
            if ($urandom_range(0, 99) == 0) wait_drained();
        end
        settle();
    endtask

    // Run limit
    initial begin
        #12_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: idle tick, then a one-step move at cruise wait
        push_item(MODE_TICK, 16'hFFFF, 1'b1, 2'd3, 16'hFFFF);
        push_item(MODE_MOVE, 16'd1, 1'b0, 2'd0, 16'd0);
        settle();

        // Directed cases with one-tick waits
        write_settings(8'd1, 8'd1, 15'd1, LINE_ROUTE_RST);
        push_item(MODE_RELEASE, 16'h0000, 1'b0, 2'd0, 16'h0000);
        push_item(MODE_SETPH, 16'h0000, 1'b0, 2'd3, 16'hFFFF);
        push_item(MODE_SETPH, 16'hFFFF, 1'b1, 2'd0, 16'h0000);
        push_item(MODE_RELEASE, 16'hFFFF, 1'b1, 2'd3, 16'hFFFF);
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            push_item(3'(m), 16'd5, 1'b0, 2'd1, 16'd1);
        // zero step count does nothing
        push_item(MODE_MOVE, 16'd0, 1'b1, 2'd2, 16'd0);
        push_item(MODE_SWING, 16'd0, 1'b0, 2'd1, 16'hFFFF);
        // commands and a spare mode while busy
        push_item(MODE_MOVE, 16'd2, 1'b0, 2'd0, 16'd0);
        push_item(MODE_SWING, 16'hFFFF, 1'b1, 2'd3, 16'hFFFF);
        push_item(MODE_SPARE_LAST, 16'hFFFF, 1'b1, 2'd3, 16'hFFFF);
        settle();
        push_item(MODE_MOVE, 16'd3, 1'b1, 2'd0, 16'd0);
        settle();
        // swing with zero hold turns round at once
        push_item(MODE_SWING, 16'd2, 1'b0, 2'd0, 16'd0);
        settle();
        push_item(MODE_SWING, 16'd1, 1'b1, 2'd0, 16'd2);
        push_item(MODE_SETPH, 16'd0, 1'b0, 2'd2, 16'd0);
        push_item(MODE_RELEASE, 16'd0, 1'b0, 2'd0, 16'd0);
        settle();
        push_item(MODE_SETPH, 16'd0, 1'b0, 2'd2, 16'd0);
        push_item(MODE_RELEASE, 16'd0, 1'b0, 2'd1, 16'd0);
        settle();

        // Low extremes, all lines from pattern bit 0
        write_settings(8'd1, 8'd1, 15'd1, 8'h00);
        run_phase(250, 40, 6);
        // High extremes: 255 ms waits, so single steps only
        write_settings(8'd255, 8'd255, 15'h7FFF, 8'hFF);
        run_phase(8, 1, 2);
        // Start below min is raised to min
        write_settings(8'd9, 8'd12, 15'd3, 8'($urandom));
        run_phase(150, 4, 4);
        // Random ramps
        write_settings(8'($urandom_range(2, 20)), 8'($urandom_range(1, 2)),
                       15'($urandom_range(1, 8)), 8'($urandom));
        run_phase(450, 16, 6);
        // Long ramp clamped to half the move, lines reversed
        write_settings(8'd6, 8'd2, 15'h7FFF, 8'h1B);
        run_phase(300, 12, 5);

        wait_drained();
        repeat (64) @(posedge aclk);

        $display("Summary: %0d input transactions, %0d moves and %0d swings commanded, %0d settings",
                 items_sent, moves_issued, swings_issued, settings_written);
        $display("Covered ramps, cruise, holds, dropped commands and spare modes under stalls");
        if (fail_total == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/srms_pkg.sv
hdl/srms_ctrl.sv
hdl/srms_dp.sv
hdl/stepper_ramped_move_sequencer.sv
tb/move_sequence_checker.sv
tb/tb_top.sv
